@@ src/csq_pkg.sv @@
// ----------------------------------------------------------------------------
// CORDIC sine package
// Shared constants and the arctangent table for the pipelined sine block.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned ITERATIONS_DEF = 32;
  localparam int unsigned ROM_DEPTH      = 32;
  localparam int unsigned ANGLE_W        = 32;
  localparam int unsigned SINE_W         = 32;
  localparam int unsigned GAIN_W         = 31;
  localparam int unsigned QUAD_W         = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd1304065743;

  // Quadrant bit that selects the cosine path, and the one that negates.
  localparam int unsigned QUAD_SEL_X = 0;
  localparam int unsigned QUAD_NEG   = 1;

  // Entry i is round(atan(2^-i) * 2^32 / pi).
  localparam logic [31:0] ATAN_ROM [ROM_DEPTH] = '{
    32'd1073741824, 32'd633866811, 32'd334917815, 32'd170009512,
    32'd85334662,   32'd42708931,  32'd21359677,  32'd10680490,
    32'd5340327,    32'd2670173,   32'd1335088,   32'd667544,
    32'd333772,     32'd166886,    32'd83443,     32'd41722,
    32'd20861,      32'd10430,     32'd5215,      32'd2608,
    32'd1304,       32'd652,       32'd326,       32'd163,
    32'd81,         32'd41,        32'd20,        32'd10,
    32'd5,          32'd3,         32'd1,         32'd1
  };

  // Table entry rounded to the nearest value of a narrower angle word.
  function automatic logic [31:0] atan_entry(int unsigned idx, int unsigned dw);
    logic [32:0] e;
    int unsigned s;
    e = {1'b0, ATAN_ROM[idx % ROM_DEPTH]};
    s = 32 - dw;
    if (s > 0) begin
      e = (e + (33'd1 << (s - 1))) >> s;
    end
    return e[31:0];
  endfunction

endpackage

@@ src/cordic_sine_quadrant_top.sv @@
// ----------------------------------------------------------------------------
// cordic_sine_quadrant_top: sine of a binary angle, rotation-mode CORDIC.
// Throughput: one angle per cycle while the output is not stalled, one pipeline register per CORDIC step.
// Reset (rst_ni low, async) clears all valid bits and loads the default gain.
// ----------------------------------------------------------------------------
module cordic_sine_quadrant_top #(
  parameter int unsigned DATA_WIDTH = csq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ITERATIONS = csq_pkg::ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Gain register write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csq_pkg::GAIN_W-1:0]          cfg_data_i,
  // Angle input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [csq_pkg::ANGLE_W-1:0]         angle_word_i,
  // Sine output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [csq_pkg::SINE_W-1:0]   sine_value_o
);
  import csq_pkg::*;

  // The table only covers 32 steps; more iterations behave as 32.
  localparam int unsigned STEPS = (ITERATIONS > ROM_DEPTH) ? ROM_DEPTH : ITERATIONS;
  localparam int unsigned DW    = DATA_WIDTH;

  // --------------------------------------------------------------------------
  // Gain register. The port is always ready; the user must write only while idle (not enforced).
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline storage. Stage k holds x, y and z after k rotation steps, plus
  // the quadrant that the output stage needs at the end.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]     x_q    [1:STEPS];
  logic signed [DW-1:0]     y_q    [1:STEPS];
  logic signed [DW-1:0]     z_q    [1:STEPS];
  logic        [QUAD_W-1:0] quad_q [1:STEPS];
  logic                     v_q    [1:STEPS];
  logic                     en     [1:STEPS];

  logic                     out_valid_q;
  logic signed [SINE_W-1:0] sine_q;
  logic                     out_en;

  // A stage may load when it is empty or when its content moves on in the
  // same cycle. Bubbles are squeezed out, so the input keeps taking angles
  // as long as some stage ahead has room, even while a result waits.
  assign out_en = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Step 0 straight from the input. The seed z is the in-quadrant angle
  // shifted left once, so its top bit is zero and the first rotation always
  // goes in the positive direction with no y term: x and y both become the
  // gain, saturated to the data width. z loses the first table entry.
  // --------------------------------------------------------------------------
  localparam logic [31:0] A0_FULL = atan_entry(0, DW);
  localparam logic [DW-1:0] A0    = A0_FULL[DW-1:0];

  logic [GAIN_W-1:0]    gain_hi;
  logic signed [DW-1:0] gain_sat;
  logic [DW-1:0]        z_seed;
  logic [DW-1:0]        z_step0;

  always_comb begin
    gain_hi = gain_q >> (DW - 1);
    if (gain_hi != '0) begin
      gain_sat = {1'b0, {(DW-1){1'b1}}};
    end else begin
      gain_sat = {1'b0, gain_q[DW-2:0]};
    end
    z_seed  = {1'b0, angle_word_i[DW-3:0], 1'b0};
    z_step0 = z_seed - A0;
  end

  genvar k;
  generate
    for (k = 1; k <= STEPS; k++) begin : g_stage
      if (k < STEPS) begin : g_en_mid
        assign en[k] = !v_q[k] || en[k+1];
      end else begin : g_en_last
        assign en[k] = !v_q[k] || out_en;
      end

      if (k == 1) begin : g_first
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            v_q[k] <= 1'b0;
          end else if (en[k]) begin
            v_q[k] <= in_valid_i;
          end
        end

        always_ff @(posedge clk_i) begin
          if (en[k] && in_valid_i) begin
            x_q[k]    <= gain_sat;
            y_q[k]    <= gain_sat;
            z_q[k]    <= z_step0;
            quad_q[k] <= angle_word_i[DW-1:DW-2];
          end
        end
      end else begin : g_rot
        // Rotation step k-1 between stage k-1 and stage k. x and y saturate,
        // z wraps. A z of zero counts as non-negative.
        localparam logic [31:0]   A_FULL = atan_entry(k - 1, DW);
        localparam logic [DW-1:0] A      = A_FULL[DW-1:0];

        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        logic signed [DW:0]   nx;
        logic signed [DW:0]   ny;
        logic signed [DW-1:0] x_d;
        logic signed [DW-1:0] y_d;
        logic        [DW-1:0] z_d;
        logic                 z_neg;

        always_comb begin
          xs    = x_q[k-1] >>> (k - 1);
          ys    = y_q[k-1] >>> (k - 1);
          z_neg = z_q[k-1][DW-1];
          if (!z_neg) begin
            nx  = {x_q[k-1][DW-1], x_q[k-1]} - {ys[DW-1], ys};
            ny  = {y_q[k-1][DW-1], y_q[k-1]} + {xs[DW-1], xs};
            z_d = z_q[k-1] - A;
          end else begin
            nx  = {x_q[k-1][DW-1], x_q[k-1]} + {ys[DW-1], ys};
            ny  = {y_q[k-1][DW-1], y_q[k-1]} - {xs[DW-1], xs};
            z_d = z_q[k-1] + A;
          end
          if (nx[DW] != nx[DW-1]) begin
            x_d = {nx[DW], {(DW-1){~nx[DW]}}};
          end else begin
            x_d = nx[DW-1:0];
          end
          if (ny[DW] != ny[DW-1]) begin
            y_d = {ny[DW], {(DW-1){~ny[DW]}}};
          end else begin
            y_d = ny[DW-1:0];
          end
        end

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            v_q[k] <= 1'b0;
          end else if (en[k]) begin
            v_q[k] <= v_q[k-1];
          end
        end

        always_ff @(posedge clk_i) begin
          if (en[k] && v_q[k-1]) begin
            x_q[k]    <= x_d;
            y_q[k]    <= y_d;
            z_q[k]    <= z_d;
            quad_q[k] <= quad_q[k-1];
          end
        end
      end
    end
  endgenerate

  assign in_stall_o = !en[1];

  // --------------------------------------------------------------------------
  // Output stage. Quadrant bit 0 picks the cosine term x instead of y, bit 1
  // negates with wrap-around (the most negative value maps to itself). The
  // data-width result is sign-extended onto the 32-bit port.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] pick;
  logic signed [DW-1:0] res;

  always_comb begin
    pick = quad_q[STEPS][QUAD_SEL_X] ? x_q[STEPS] : y_q[STEPS];
    res  = quad_q[STEPS][QUAD_NEG] ? -pick : pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && v_q[STEPS]) begin
      sine_q <= SINE_W'(res);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sine_value_o = sine_q;

  // --------------------------------------------------------------------------
  // Checks on the pipeline control.
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // The input side only stalls when the result side is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side is free");

  // An accepted angle lands in the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[1])
    else $error("accepted angle lost at pipeline entry");

  // A finished item that moves on becomes the visible result.
  a_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STEPS] && out_en) |=> out_valid_o)
    else $error("last stage item dropped before output");

  // A held last stage keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STEPS] && !en[STEPS]) |=> ($stable(x_q[STEPS]) && $stable(y_q[STEPS])))
    else $error("stalled last stage changed");
`endif

endmodule
